[design/tsbs_pkg.sv]
// Shared types and constants of the texture store bilinear sampler.
// Used by every design file but tsbs_ram; depends on nothing.
package tsbs_pkg;

  localparam int COORD_W   = 24;
  localparam int CHAN_W    = 16;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int MOD_STEPS = COORD_W;
  localparam int CNT_W     = 5;

  typedef enum logic [2:0] {
    KIND_WR_DISCARD = 3'd0,
    KIND_WR_WRAP    = 3'd1,
    KIND_RD_CLAMP   = 3'd2,
    KIND_RD_WRAP    = 3'd3,
    KIND_SAMPLE     = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // corner select: bit 1 picks x1, bit 0 picks y1
  localparam logic [1:0] CORNER_00 = 2'd0;

  typedef struct packed {
    logic       load;
    logic       coord;
    logic       mod_step;
    logic       mod_fix;
    logic       addr_ld;
    logic [1:0] corner;
    logic       ram_we;
    logic       cap_pa;
    logic       cap_r0;
    logic       cap_r1;
    logic       cap_res_rd;
    logic       cap_res_lerp;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       inb;
  } dp_stat_t;

endpackage

[design/tsbs_if.sv]
// Request and result channel interfaces of the texture store bilinear sampler.
// Depends on tsbs_pkg for field widths.
interface tsbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           kind;
  logic signed [tsbs_pkg::COORD_W-1:0]  coord_x;
  logic signed [tsbs_pkg::COORD_W-1:0]  coord_y;
  logic [tsbs_pkg::CHAN_W-1:0]          red_in;
  logic [tsbs_pkg::CHAN_W-1:0]          green_in;
  logic [tsbs_pkg::CHAN_W-1:0]          blue_in;
  logic [tsbs_pkg::CHAN_W-1:0]          alpha_in;

  modport source (output valid, kind, coord_x, coord_y, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink   (input valid, kind, coord_x, coord_y, red_in, green_in, blue_in, alpha_in,
                  output ready);
endinterface

interface tsbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [tsbs_pkg::CHAN_W-1:0] red_out;
  logic [tsbs_pkg::CHAN_W-1:0] green_out;
  logic [tsbs_pkg::CHAN_W-1:0] blue_out;
  logic [tsbs_pkg::CHAN_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

[design/texture_store_bilinear_sampler_unit.sv]
// Top level of the texture store bilinear sampler: controller plus datapath.
// Uses tsbs_pkg, tsbs_if, tsbs_ctrl, tsbs_dp.
//
//   channel   dir  handshake          payload
//   in_req    in   valid/ready        kind, coord_x, coord_y, red/green/blue/alpha_in
//   out_rsp   out  valid/ready        red/green/blue/alpha_out
//   cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Request time is set by the single store port (four reads per sample) and the
// one-bit-per-cycle remainder unit. A new request is taken only once the
// controller is back in its idle state.
// Synchronous reset clears control and sets the two dimension registers to one,
// nothing else; the store holds garbage until written. A new request is taken
// while a result still waits in the output register; a stalled output holds
// the block in its final step.
module texture_store_bilinear_sampler_unit #(
  parameter int MAX_DIM      = 256,
  parameter int CHANNEL_BITS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tsbs_in_if.sink                        in_req,
  tsbs_out_if.source                     out_rsp,
  input  logic                           cfg_we,
  input  logic [tsbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsbs_pkg::CFG_W-1:0]     cfg_data
);

  tsbs_pkg::dp_cmd_t  cmd;
  tsbs_pkg::dp_stat_t stat;

  tsbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tsbs_dp #(
    .MAX_DIM      (MAX_DIM),
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .kind      (in_req.kind),
    .coord_x   (in_req.coord_x),
    .coord_y   (in_req.coord_y),
    .red_in    (in_req.red_in),
    .green_in  (in_req.green_in),
    .blue_in   (in_req.blue_in),
    .alpha_in  (in_req.alpha_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .red_out   (out_rsp.red_out),
    .green_out (out_rsp.green_out),
    .blue_out  (out_rsp.blue_out),
    .alpha_out (out_rsp.alpha_out)
  );

endmodule

[design/tsbs_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module tsbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wr_data;
    end
    rd_data_r <= mem_r[addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/tsbs_dp.sv]
// Datapath: config registers, coordinate unit, remainder unit, address,
// pixel store, shared lerp lanes and result register. Uses tsbs_pkg, tsbs_ram.
module tsbs_dp #(
  parameter int MAX_DIM      = 256,
  parameter int CHANNEL_BITS = 16,
  parameter int FRAC_BITS    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tsbs_pkg::dp_cmd_t                    cmd,
  output tsbs_pkg::dp_stat_t                   stat,
  input  logic [2:0]                           kind,
  input  logic signed [tsbs_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [tsbs_pkg::COORD_W-1:0]  coord_y,
  input  logic [tsbs_pkg::CHAN_W-1:0]          red_in,
  input  logic [tsbs_pkg::CHAN_W-1:0]          green_in,
  input  logic [tsbs_pkg::CHAN_W-1:0]          blue_in,
  input  logic [tsbs_pkg::CHAN_W-1:0]          alpha_in,
  input  logic                                 cfg_we,
  input  logic [tsbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsbs_pkg::CFG_W-1:0]           cfg_data,
  output logic [tsbs_pkg::CHAN_W-1:0]          red_out,
  output logic [tsbs_pkg::CHAN_W-1:0]          green_out,
  output logic [tsbs_pkg::CHAN_W-1:0]          blue_out,
  output logic [tsbs_pkg::CHAN_W-1:0]          alpha_out
);

  localparam int CW     = tsbs_pkg::COORD_W;
  localparam int CB     = CHANNEL_BITS;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
  localparam int PIX_W  = 4 * CB;
  localparam int CLW    = CW + 2;
  localparam int HALF   = 1 << (FRAC_BITS - 1);
  localparam int LW     = CB + FRAC_BITS + 2;
  localparam int PW     = IDX_W + DIM_W;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [tsbs_pkg::CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > 32'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(v);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_c(input logic signed [CLW-1:0] c,
                                               input logic [DIM_W-1:0] dim);
    logic signed [CLW-1:0] lim;
    logic [IDX_W-1:0]      r;
    lim = $signed(CLW'(dim) - CLW'(1));
    if (c < 0) r = '0;
    else if (c > lim) r = IDX_W'(lim);
    else r = IDX_W'(c);
    return r;
  endfunction

  logic [tsbs_pkg::CFG_W-1:0] width_r, height_r;
  logic [DIM_W-1:0]           w_eff, h_eff;

  logic [2:0]                 kind_r;
  logic signed [CW-1:0]       cx_r, cy_r;
  logic [PIX_W-1:0]           px_r;

  logic [IDX_W-1:0]           x0_r, x1_r, y0_r, y1_r;
  logic [FRAC_BITS-1:0]       fx_r, fy_r;

  logic [DIM_W-1:0]           mrem_x_r, mrem_y_r;
  logic [CW-1:0]              mq_x_r, mq_y_r;
  logic                       neg_x_r, neg_y_r;

  logic [AW-1:0]              addr_r;
  logic [PIX_W-1:0]           pa_r, r0_r, r1_r, res_r, out_px_r;
  logic [PIX_W-1:0]           ram_rd_data;

  logic signed [CLW-1:0]      cxe, cye, ux, uy, ix, iy, ix1, iy1;
  logic [CW-1:0]              mag_x, mag_y;
  logic [DIM_W:0]             tx, ty;
  logic [DIM_W-1:0]           mrem_x_nxt, mrem_y_nxt;
  logic [IDX_W-1:0]           xs, ys;
  logic [PW-1:0]              prod;
  logic [AW-1:0]              addr_nxt;
  logic                       inb;

  logic [PIX_W-1:0]           la, lb, lerp_res;
  logic [FRAC_BITS-1:0]       lt;

  assign w_eff = eff_dim(width_r);
  assign h_eff = eff_dim(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tsbs_pkg::CFG_W'(1);
      height_r <= tsbs_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsbs_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        tsbs_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // coordinate unit
  assign cxe   = CLW'(cx_r);
  assign cye   = CLW'(cy_r);
  assign ux    = cxe - CLW'(HALF);
  assign uy    = cye - CLW'(HALF);
  assign ix    = ux >>> FRAC_BITS;
  assign iy    = uy >>> FRAC_BITS;
  assign ix1   = ix + CLW'(1);
  assign iy1   = iy + CLW'(1);
  assign inb   = (cxe >= 0) && (cye >= 0) &&
                 (cxe < $signed(CLW'(w_eff))) && (cye < $signed(CLW'(h_eff)));
  assign mag_x = cx_r[CW-1] ? ($unsigned(~cx_r) + CW'(1)) : $unsigned(cx_r);
  assign mag_y = cy_r[CW-1] ? ($unsigned(~cy_r) + CW'(1)) : $unsigned(cy_r);

  // restoring remainder, one quotient bit per step
  assign tx = {mrem_x_r, mq_x_r[CW-1]};
  assign ty = {mrem_y_r, mq_y_r[CW-1]};
  assign mrem_x_nxt = (tx >= {1'b0, w_eff}) ? DIM_W'(tx - {1'b0, w_eff}) : DIM_W'(tx);
  assign mrem_y_nxt = (ty >= {1'b0, h_eff}) ? DIM_W'(ty - {1'b0, h_eff}) : DIM_W'(ty);

  // address of the selected corner
  assign xs       = cmd.corner[1] ? x1_r : x0_r;
  assign ys       = cmd.corner[0] ? y1_r : y0_r;
  assign prod     = PW'(ys) * PW'(w_eff);
  assign addr_nxt = AW'(prod + PW'(xs));

  // shared lerp lanes: a*S + (b-a)*t + S/2, then drop the fraction
  assign la = cmd.cap_res_lerp ? r0_r : pa_r;
  assign lb = cmd.cap_res_lerp ? r1_r : ram_rd_data;
  assign lt = cmd.cap_res_lerp ? fx_r : fy_r;

  always_comb begin
    logic [CB-1:0]        ca, cb_v;
    logic signed [CB:0]   diff;
    logic signed [LW-1:0] prd, acc;
    lerp_res = '0;
    for (int c = 0; c < 4; c++) begin
      ca   = la[c*CB +: CB];
      cb_v = lb[c*CB +: CB];
      diff = $signed({1'b0, cb_v}) - $signed({1'b0, ca});
      prd  = diff * $signed({1'b0, lt});
      acc  = $signed({2'b00, ca, {FRAC_BITS{1'b0}}}) + prd + $signed(LW'(HALF));
      lerp_res[c*CB +: CB] = acc[FRAC_BITS +: CB];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      cx_r   <= coord_x;
      cy_r   <= coord_y;
      px_r   <= {alpha_in[CB-1:0], blue_in[CB-1:0], green_in[CB-1:0], red_in[CB-1:0]};
    end
    if (cmd.coord) begin
      if (kind_r == tsbs_pkg::KIND_SAMPLE) begin
        x0_r <= clamp_c(ix, w_eff);
        x1_r <= clamp_c(ix1, w_eff);
        y0_r <= clamp_c(iy, h_eff);
        y1_r <= clamp_c(iy1, h_eff);
      end else begin
        x0_r <= clamp_c(cxe, w_eff);
        y0_r <= clamp_c(cye, h_eff);
      end
      fx_r     <= ux[FRAC_BITS-1:0];
      fy_r     <= uy[FRAC_BITS-1:0];
      mrem_x_r <= '0;
      mrem_y_r <= '0;
      mq_x_r   <= mag_x;
      mq_y_r   <= mag_y;
      neg_x_r  <= cx_r[CW-1];
      neg_y_r  <= cy_r[CW-1];
    end
    if (cmd.mod_step) begin
      mrem_x_r <= mrem_x_nxt;
      mrem_y_r <= mrem_y_nxt;
      mq_x_r   <= mq_x_r << 1;
      mq_y_r   <= mq_y_r << 1;
    end
    if (cmd.mod_fix) begin
      x0_r <= (neg_x_r && mrem_x_r != '0) ? IDX_W'(w_eff - mrem_x_r) : IDX_W'(mrem_x_r);
      y0_r <= (neg_y_r && mrem_y_r != '0) ? IDX_W'(h_eff - mrem_y_r) : IDX_W'(mrem_y_r);
    end
    if (cmd.addr_ld)      addr_r   <= addr_nxt;
    if (cmd.cap_pa)       pa_r     <= ram_rd_data;
    if (cmd.cap_r0)       r0_r     <= lerp_res;
    if (cmd.cap_r1)       r1_r     <= lerp_res;
    if (cmd.cap_res_rd)   res_r    <= ram_rd_data;
    if (cmd.cap_res_lerp) res_r    <= lerp_res;
    if (cmd.out_load)     out_px_r <= res_r;
  end

  tsbs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_store (
    .clk     (clk),
    .we      (cmd.ram_we),
    .addr    (addr_r),
    .wr_data (px_r),
    .rd_data (ram_rd_data)
  );

  assign stat.kind = kind_r;
  assign stat.inb  = inb;

  assign red_out   = tsbs_pkg::CHAN_W'(out_px_r[0*CB +: CB]);
  assign green_out = tsbs_pkg::CHAN_W'(out_px_r[1*CB +: CB]);
  assign blue_out  = tsbs_pkg::CHAN_W'(out_px_r[2*CB +: CB]);
  assign alpha_out = tsbs_pkg::CHAN_W'(out_px_r[3*CB +: CB]);

endmodule

[design/tsbs_ctrl.sv]
// Controller: sequences one request through coordinate, remainder, store
// access and interpolation steps, and owns the result valid. Uses tsbs_pkg.
module tsbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tsbs_pkg::dp_stat_t  stat,
  output tsbs_pkg::dp_cmd_t   cmd
);

  localparam int CNT_W = tsbs_pkg::CNT_W;
  // read phases: store data shows once the address has passed addr_r and the store's read register
  localparam logic [CNT_W-1:0] PH_LAST_ADDR = CNT_W'(3);
  localparam logic [CNT_W-1:0] PH_P00       = CNT_W'(2);
  localparam logic [CNT_W-1:0] PH_P01       = CNT_W'(3);
  localparam logic [CNT_W-1:0] PH_P10       = CNT_W'(4);
  localparam logic [CNT_W-1:0] PH_P11       = CNT_W'(5);
  localparam logic [CNT_W-1:0] MOD_LAST     = CNT_W'(tsbs_pkg::MOD_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_COORD, S_MOD, S_MFIX, S_ADDR, S_WR, S_RD, S_LERPX, S_PUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_COORD;
        end
      end
      S_COORD: begin
        cmd.coord = 1'b1;
        cnt_nxt   = '0;
        unique case (stat.kind) inside
          tsbs_pkg::KIND_WR_DISCARD:                      state_nxt = stat.inb ? S_ADDR : S_IDLE;
          tsbs_pkg::KIND_WR_WRAP, tsbs_pkg::KIND_RD_WRAP: state_nxt = S_MOD;
          tsbs_pkg::KIND_RD_CLAMP, tsbs_pkg::KIND_SAMPLE: state_nxt = S_RD;
          default:                                        state_nxt = S_IDLE;
        endcase
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt_r == MOD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_MFIX;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_MFIX: begin
        cmd.mod_fix = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = (stat.kind == tsbs_pkg::KIND_WR_WRAP) ? S_ADDR : S_RD;
      end
      S_ADDR: begin
        cmd.addr_ld = 1'b1;
        cmd.corner  = tsbs_pkg::CORNER_00;
        state_nxt   = S_WR;
      end
      S_WR: begin
        cmd.ram_we = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD: begin
        cmd.addr_ld = (cnt_r <= PH_LAST_ADDR);
        cmd.corner  = cnt_r[1:0];
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (stat.kind != tsbs_pkg::KIND_SAMPLE) begin
          if (cnt_r == PH_P00) begin
            cmd.cap_res_rd = 1'b1;
            state_nxt      = S_PUT;
          end
        end else begin
          cmd.cap_pa = (cnt_r == PH_P00) || (cnt_r == PH_P10);
          cmd.cap_r0 = (cnt_r == PH_P01);
          cmd.cap_r1 = (cnt_r == PH_P11);
          if (cnt_r == PH_P11) state_nxt = S_LERPX;
        end
      end
      S_LERPX: begin
        cmd.cap_res_lerp = 1'b1;
        state_nxt        = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/tsbs_checker.sv]
// Port-level checks of the texture store bilinear sampler, bound to the top.
// Depends on tsbs_pkg and texture_store_bilinear_sampler_unit.
module tsbs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tsbs_pkg::CHAN_W-1:0] red_out,
  input logic [tsbs_pkg::CHAN_W-1:0] green_out,
  input logic [tsbs_pkg::CHAN_W-1:0] blue_out,
  input logic [tsbs_pkg::CHAN_W-1:0] alpha_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({red_out, green_out, blue_out, alpha_out}))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without the block being busy");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not return to idle");

endmodule

bind texture_store_bilinear_sampler_unit tsbs_checker u_tsbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .red_out   (out_rsp.red_out),
  .green_out (out_rsp.green_out),
  .blue_out  (out_rsp.blue_out),
  .alpha_out (out_rsp.alpha_out)
);
